// ===== rtl/dcmm_pkg.sv =====
// ----------------------------------------------------------------------------
// dcmm_pkg
// Shared types and constants of the dual comparator mode mux.
// ----------------------------------------------------------------------------
package dcmm_pkg;

   localparam int LEVEL_BITS = 12;

   typedef logic [LEVEL_BITS-1:0] level_type;
   typedef logic [2:0]            mode_type;

   // opcodes
   localparam logic OP_LEVEL   = 1'b0;
   localparam logic OP_CONTROL = 1'b1;

   // channel of the reference level
   localparam logic [2:0] CH_REFERENCE = 3'd4;

   // routing modes
   localparam mode_type MODE_TIED         = 3'd0;
   localparam mode_type MODE_SHARED_CIS   = 3'd1;
   localparam mode_type MODE_REF_MUX      = 3'd2;
   localparam mode_type MODE_SHARED       = 3'd3;
   localparam mode_type MODE_INDEPENDENT  = 3'd4;
   localparam mode_type MODE_ONE_OFF      = 3'd5;
   localparam mode_type MODE_SHARED_DRIVE = 3'd6;
   localparam mode_type MODE_OFF          = 3'd7;

   // control byte bit positions
   localparam int BIT_CIS   = 3;
   localparam int BIT_C1INV = 4;
   localparam int BIT_C2INV = 5;
   localparam int BIT_C1OUT = 6;
   localparam int BIT_C2OUT = 7;

   typedef struct packed {
      logic first_out;    // compare, inverted when C1INV is set, goes to C1OUT
      logic second_out;   // compare, inverted when C2INV is set, goes to C2OUT
      logic first_equal;
      logic second_equal;
   } cmp_result_type;

endpackage

// ===== rtl/dual_comparator_mode_mux.sv =====
// ----------------------------------------------------------------------------
// dual_comparator_mode_mux
// Dual analog comparator with eight routing modes and a control byte.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one beat per item: a level update (pin 0..3 or the
//   reference level) or a control byte write. rsp_* returns exactly one
//   beat per request with the updated control byte, its previous value,
//   the change mask and the comparator levels.
//   An accepted request is loaded into the input register; the routing,
//   compares and state update then move it into the response register.
//   One beat is accepted every cycle while req_stall is low; the state
//   update of one beat is registered with its response and is seen by
//   the next beat.
//   Reset clears the pin levels, reference level and control byte and
//   empties both register stages.
//   While rsp_stall is high the response holds; one more request may
//   enter the input register, after which req_stall is raised.
// ----------------------------------------------------------------------------
module dual_comparator_mode_mux (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [2:0]  req_channel,
   input  logic [11:0] req_sample,
   input  logic [7:0]  req_control_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_status_byte,
   output logic [7:0]  rsp_previous_byte,
   output logic [7:0]  rsp_changed_mask,
   output logic        rsp_change_report,
   output logic        rsp_first_level,
   output logic        rsp_second_level,
   output logic        rsp_first_equal,
   output logic        rsp_second_equal,
   output logic        rsp_pins_driven
);
   import dcmm_pkg::*;

   // input register
   logic        s1_valid_ff;
   logic        s1_opcode_ff;
   logic [2:0]  s1_channel_ff;
   logic [11:0] s1_sample_ff;
   logic [7:0]  s1_control_ff;

   // block state
   level_type   pins_ff [4];
   level_type   pins_in [4];
   level_type   reference_ff;
   level_type   reference_in;
   logic [7:0]  control_ff;
   logic [7:0]  control_in;
   logic [7:0]  written;

   // response register
   logic        rsp_valid_ff;
   logic [7:0]  status_ff;
   logic [7:0]  previous_ff;
   logic        report_ff;
   logic        level1_ff;
   logic        level2_ff;
   logic        equal1_ff;
   logic        equal2_ff;

   logic           s1_advance;
   logic           req_take;
   level_type      sample_level;
   cmp_result_type cmp;

   assign s1_advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = s1_valid_ff && !s1_advance;
   assign req_take     = req_valid && !req_stall;
   assign sample_level = LEVEL_BITS'(s1_sample_ff);

   always_comb begin
      pins_in      = pins_ff;
      reference_in = reference_ff;
      written      = control_ff;
      if (s1_opcode_ff == OP_CONTROL) begin
         written = s1_control_ff;
      end else if (s1_channel_ff < CH_REFERENCE) begin
         pins_in[s1_channel_ff[1:0]] = sample_level;
      end else if (s1_channel_ff == CH_REFERENCE) begin
         reference_in = sample_level;
      end
   end

   dcmm_eval u_eval (
      .pin_levels      (pins_in),
      .reference_level (reference_in),
      .control         (written),
      .result          (cmp)
   );

   assign control_in = {cmp.second_out, cmp.first_out, written[5:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pins_ff      <= '{default: '0};
         reference_ff <= '0;
         control_ff   <= '0;
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_advance) begin
            rsp_valid_ff <= 1'b1;
            pins_ff      <= pins_in;
            reference_ff <= reference_in;
            control_ff   <= control_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_opcode_ff  <= req_opcode;
         s1_channel_ff <= req_channel;
         s1_sample_ff  <= req_sample;
         s1_control_ff <= req_control_value;
      end
      if (s1_advance) begin
         status_ff   <= control_in;
         previous_ff <= control_ff;
         // level updates never report, even when the output bits move
         report_ff   <= (s1_opcode_ff == OP_CONTROL) && (control_in != control_ff);
         level1_ff   <= cmp.first_out && !cmp.first_equal;
         level2_ff   <= cmp.second_out && !cmp.second_equal;
         equal1_ff   <= cmp.first_equal;
         equal2_ff   <= cmp.second_equal;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status_byte   = status_ff;
   assign rsp_previous_byte = previous_ff;
   assign rsp_changed_mask  = status_ff ^ previous_ff;
   assign rsp_change_report = report_ff;
   assign rsp_first_level   = level1_ff;
   assign rsp_second_level  = level2_ff;
   assign rsp_first_equal   = equal1_ff;
   assign rsp_second_equal  = equal2_ff;
   assign rsp_pins_driven   = (status_ff[2:0] == MODE_SHARED_DRIVE);

endmodule

// ===== rtl/dcmm_eval.sv =====
// ----------------------------------------------------------------------------
// dcmm_eval
// Mode routing and the two magnitude comparators.
// ----------------------------------------------------------------------------
module dcmm_eval (
   input  dcmm_pkg::level_type      pin_levels [4],
   input  dcmm_pkg::level_type      reference_level,
   input  logic [7:0]               control,
   output dcmm_pkg::cmp_result_type result
);
   import dcmm_pkg::*;

   mode_type  mode;
   logic      cis;
   level_type vin1;
   level_type ref1;
   level_type vin2;
   level_type ref2;

   assign mode = control[2:0];
   assign cis  = control[BIT_CIS];

   always_comb begin
      ref1 = pin_levels[0];
      vin1 = pin_levels[3];
      ref2 = pin_levels[1];
      vin2 = pin_levels[2];
      unique case (mode)
         MODE_TIED: begin
            vin1 = pin_levels[0];
            vin2 = pin_levels[1];
         end
         MODE_SHARED_CIS: begin
            ref1 = cis ? pin_levels[3] : pin_levels[0];
            vin1 = pin_levels[2];
         end
         MODE_REF_MUX: begin
            ref1 = cis ? pin_levels[3] : pin_levels[0];
            ref2 = cis ? pin_levels[2] : pin_levels[1];
            vin1 = reference_level;
            vin2 = reference_level;
         end
         MODE_SHARED, MODE_SHARED_DRIVE: begin
            vin1 = pin_levels[2];
         end
         MODE_INDEPENDENT: begin
         end
         MODE_ONE_OFF: begin
            vin1 = '0;
            ref1 = '0;
         end
         MODE_OFF: begin
            vin1 = '0;
            ref1 = '0;
            vin2 = '0;
            ref2 = '0;
         end
      endcase
   end

   assign result.first_out    = (vin1 > ref1) ^ control[BIT_C1INV];
   assign result.second_out   = (vin2 > ref2) ^ control[BIT_C2INV];
   assign result.first_equal  = (vin1 == ref1);
   assign result.second_equal = (vin2 == ref2);

endmodule
